// File: hw/rtl/csr_spmv_pkg.sv
// Shared types and constants for the CSR sparse matrix-vector row accumulator.
// Holds the command codes, field widths, register indexes and result word layout.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package csr_spmv_pkg;

    // Field widths of the streaming words.
    localparam int CMD_W    = 2;
    localparam int COL_W    = 12;
    localparam int VAL_W    = 32;
    localparam int ROW_W    = 20;
    localparam int SUM_W    = 48;
    localparam int PROD_W   = 64;

    // Packed word widths, padded up to whole bytes.
    localparam int S_DATA_W = 112;
    localparam int S_USER_W = 8;
    localparam int M_DATA_W = 56;
    localparam int M_USER_W = 8;

    // Configuration port.
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    // Command codes carried in the input tuser.
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_X   = 2'd0,
        CMD_NONZERO  = 2'd1,
        CMD_END_ROW  = 2'd2,
        CMD_RESTART  = 2'd3
    } cmd_t;

    // Register indexes, selected by paddr[2].
    localparam logic REG_ALPHA = 1'b0;
    localparam logic REG_BETA  = 1'b1;

    // Reset values of the scale registers (Q16.16).
    localparam logic [VAL_W-1:0] ALPHA_RESET = 32'h0001_0000;
    localparam logic [VAL_W-1:0] BETA_RESET  = 32'h0000_0000;

    // Saturation limits of the row sum.
    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // One finished row as it sits in the output queue.
    typedef struct packed {
        logic             saturated;
        logic [VAL_W-1:0] row_result;
        logic [ROW_W-1:0] row_index;
    } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/csr_spmv_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// A read and a write of the same address in one cycle return the old data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module csr_spmv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write and registered read.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/csr_spmv_row_accumulator.sv
// Top level of the CSR sparse matrix-vector row accumulator (y = alpha*A*x + beta*y).
// Depends on csr_spmv_pkg and csr_spmv_ram (x vector store).
//
//  Channel  Direction  Handshake          Contents
//  s_       in         tvalid/tready      tuser: command; tdata: column, x, matrix, prior y
//  m_       out        tvalid/tready      tdata: row index, row result; tuser: saturated
//  APB      in         psel/penable/...   alpha at 0x0, beta at 0x4, pready always high
//
// One word is accepted per cycle while s_tready is high. The pipeline depth from an
// end-of-row word to its result is set by the x store read, the shared 32x32 multiplier
// and the split alpha multiply. Results wait in an eight-entry queue, and s_tready drops
// only while eight results are queued or in flight. Reset is synchronous and active low;
// it clears the row sum, row counter and queue and restores the default scales; the x
// store keeps no reset.
`timescale 1ns / 1ps
`default_nettype none

module csr_spmv_row_accumulator #(
    parameter int X_DEPTH  = 4096,
    parameter int MAX_ROWS = 1048576
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // [11:0] column, [43:12] x_entry, [75:44] matrix_entry, [107:76] prior_y
    input  wire logic [csr_spmv_pkg::S_DATA_W-1:0]   s_tdata,
    // [1:0] command
    input  wire logic [csr_spmv_pkg::S_USER_W-1:0]   s_tuser,

    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [19:0] row_index, [51:20] row_result
    output logic      [csr_spmv_pkg::M_DATA_W-1:0]   m_tdata,
    // [0] saturated
    output logic      [csr_spmv_pkg::M_USER_W-1:0]   m_tuser,

    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [csr_spmv_pkg::APB_AW-1:0]     paddr,
    input  wire logic [csr_spmv_pkg::APB_DW-1:0]     pwdata,
    output logic      [csr_spmv_pkg::APB_DW-1:0]     prdata,
    output logic                                     pready
);

    localparam int AW       = $clog2(X_DEPTH);
    localparam int CNT_W    = $clog2(MAX_ROWS);
    localparam int VAL_W    = csr_spmv_pkg::VAL_W;
    localparam int COL_W    = csr_spmv_pkg::COL_W;
    localparam int SUM_W    = csr_spmv_pkg::SUM_W;
    localparam int PROD_W   = csr_spmv_pkg::PROD_W;
    localparam int ROW_W    = csr_spmv_pkg::ROW_W;
    localparam int Q_DEPTH  = 8;
    localparam int QP_W     = $clog2(Q_DEPTH);
    localparam int CRED_W   = $clog2(Q_DEPTH + 1);
    localparam int HALF_W   = 24;
    localparam int HI_W     = HALF_W + VAL_W;
    localparam int LO_W     = HALF_W + VAL_W + 1;
    localparam int LOWER_W  = PROD_W + 1;
    localparam int RES_W    = PROD_W + 2;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [VAL_W-1:0] alpha_reg;
    logic [VAL_W-1:0] beta_reg;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == csr_spmv_pkg::REG_BETA) ? beta_reg : alpha_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg <= csr_spmv_pkg::ALPHA_RESET;
            beta_reg  <= csr_spmv_pkg::BETA_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == csr_spmv_pkg::REG_BETA) begin
                beta_reg <= pwdata;
            end else begin
                alpha_reg <= pwdata;
            end
        end
    end

    // ------------------------------------------------------------------
    // Input unpacking and flow control.
    // ------------------------------------------------------------------
    csr_spmv_pkg::cmd_t in_cmd;
    logic [COL_W-1:0]   in_col;
    logic               s_accept;
    logic               m_accept;
    logic [CRED_W-1:0]  credit_reg;

    assign in_cmd   = csr_spmv_pkg::cmd_t'(s_tuser[1:0]);
    assign in_col   = s_tdata[11:0];
    assign s_tready = (credit_reg != CRED_W'(Q_DEPTH));
    assign s_accept = s_tvalid && s_tready;
    assign m_accept = m_tvalid && m_tready;

    // Each end-of-row word reserves a queue slot until its result is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            credit_reg <= '0;
        end else begin
            case ({s_accept && (in_cmd == csr_spmv_pkg::CMD_END_ROW), m_accept})
                2'b10:   credit_reg <= credit_reg + CRED_W'(1);
                2'b01:   credit_reg <= credit_reg - CRED_W'(1);
                default: credit_reg <= credit_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: input register.
    // ------------------------------------------------------------------
    logic               p0_valid_reg;
    csr_spmv_pkg::cmd_t p0_cmd_reg;
    logic [COL_W-1:0]   p0_col_reg;
    logic [VAL_W-1:0]   p0_x_reg;
    logic [VAL_W-1:0]   p0_mat_reg;
    logic [VAL_W-1:0]   p0_prior_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p0_valid_reg <= 1'b0;
        end else begin
            p0_valid_reg <= s_accept;
        end
        p0_cmd_reg   <= in_cmd;
        p0_col_reg   <= in_col;
        p0_x_reg     <= s_tdata[43:12];
        p0_mat_reg   <= s_tdata[75:44];
        p0_prior_reg <= s_tdata[107:76];
    end

    // ------------------------------------------------------------------
    // Store address: column modulo the store depth.
    // ------------------------------------------------------------------
    logic [AW-1:0] x_addr;

    generate
        if (X_DEPTH <= (1 << COL_W)) begin : g_wrap
            // Reciprocal multiply gives the exact quotient for a 12-bit column.
            localparam int RSH = 2 * COL_W;
            localparam int RW  = RSH + 1;
            localparam int PW  = RW + COL_W;
            localparam logic [RW-1:0] RECIP = RW'(((1 << RSH) + X_DEPTH - 1) / X_DEPTH);

            logic [PW-1:0]    q_prod;
            logic [COL_W-1:0] quot_reg;
            logic [RW-1:0]    q_times_d;
            logic [RW-1:0]    col_rem;

            assign q_prod = {{RW{1'b0}}, in_col} * {{COL_W{1'b0}}, RECIP};

            always_ff @(posedge aclk) begin
                quot_reg <= q_prod[RSH +: COL_W];
            end

            assign q_times_d = {{(RW-COL_W){1'b0}}, quot_reg} * RW'(X_DEPTH);
            assign col_rem   = {{(RW-COL_W){1'b0}}, p0_col_reg} - q_times_d;
            assign x_addr    = col_rem[AW-1:0];
        end else begin : g_nowrap
            assign x_addr = {{(AW-COL_W){1'b0}}, p0_col_reg};
        end
    endgenerate

    // ------------------------------------------------------------------
    // x store: loads write here, nonzeros read here.
    // ------------------------------------------------------------------
    logic [VAL_W-1:0] x_rdata;

    csr_spmv_ram #(
        .WIDTH (VAL_W),
        .DEPTH (X_DEPTH)
    ) u_x_store (
        .aclk  (aclk),
        .we    (p0_valid_reg && (p0_cmd_reg == csr_spmv_pkg::CMD_LOAD_X)),
        .waddr (x_addr),
        .wdata (p0_x_reg),
        .re    (p0_valid_reg && (p0_cmd_reg == csr_spmv_pkg::CMD_NONZERO)),
        .raddr (x_addr),
        .rdata (x_rdata)
    );

    // ------------------------------------------------------------------
    // Stage 1: item waits for the store read.
    // ------------------------------------------------------------------
    logic               p1_valid_reg;
    csr_spmv_pkg::cmd_t p1_cmd_reg;
    logic [VAL_W-1:0]   p1_mat_reg;
    logic [VAL_W-1:0]   p1_prior_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= p0_valid_reg;
        end
        p1_cmd_reg   <= p0_cmd_reg;
        p1_mat_reg   <= p0_mat_reg;
        p1_prior_reg <= p0_prior_reg;
    end

    // ------------------------------------------------------------------
    // Stage 2: one shared multiplier, matrix*x for a nonzero, beta*prior_y
    // for an end of row.
    // ------------------------------------------------------------------
    logic               p2_valid_reg;
    csr_spmv_pkg::cmd_t p2_cmd_reg;
    logic [PROD_W-1:0]  p2_prod_reg;
    logic [VAL_W-1:0]   mul_a;
    logic [VAL_W-1:0]   mul_b;
    logic [PROD_W-1:0]  mul_p;

    assign mul_a = (p1_cmd_reg == csr_spmv_pkg::CMD_END_ROW) ? beta_reg : p1_mat_reg;
    assign mul_b = (p1_cmd_reg == csr_spmv_pkg::CMD_END_ROW) ? p1_prior_reg : x_rdata;
    assign mul_p = PROD_W'($signed(mul_a) * $signed(mul_b));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else begin
            p2_valid_reg <= p1_valid_reg;
        end
        p2_cmd_reg  <= p1_cmd_reg;
        p2_prod_reg <= mul_p;
    end

    // ------------------------------------------------------------------
    // Stage 3: row state. Saturating accumulate, row close and restart.
    // ------------------------------------------------------------------
    logic [SUM_W-1:0]  row_sum_reg;
    logic              ovf_seen_reg;
    logic [CNT_W-1:0]  row_cnt_reg;
    logic [SUM_W:0]    sum_wide;
    logic [SUM_W-1:0]  sum_next;
    logic              sum_ovf;
    logic [CNT_W+ROW_W-1:0] idx_wide;

    logic              p3_valid_reg;
    logic [SUM_W-1:0]  p3_sum_reg;
    logic              p3_ovf_reg;
    logic [ROW_W-1:0]  p3_idx_reg;
    logic [PROD_W-1:0] p3_bprod_reg;

    // The product floored to Q16.16 is its bits from 16 up.
    assign sum_wide = {row_sum_reg[SUM_W-1], row_sum_reg}
                    + {p2_prod_reg[PROD_W-1], p2_prod_reg[PROD_W-1:16]};
    assign sum_ovf  = (sum_wide[SUM_W] != sum_wide[SUM_W-1]);
    assign sum_next = sum_ovf ? (sum_wide[SUM_W] ? csr_spmv_pkg::SUM_MIN
                                                 : csr_spmv_pkg::SUM_MAX)
                              : sum_wide[SUM_W-1:0];
    assign idx_wide = {{ROW_W{1'b0}}, row_cnt_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_sum_reg  <= '0;
            ovf_seen_reg <= 1'b0;
            row_cnt_reg  <= '0;
            p3_valid_reg <= 1'b0;
        end else begin
            p3_valid_reg <= p2_valid_reg && (p2_cmd_reg == csr_spmv_pkg::CMD_END_ROW);
            if (p2_valid_reg) begin
                case (p2_cmd_reg)
                    csr_spmv_pkg::CMD_NONZERO: begin
                        row_sum_reg  <= sum_next;
                        ovf_seen_reg <= ovf_seen_reg || sum_ovf;
                    end
                    csr_spmv_pkg::CMD_END_ROW: begin
                        row_sum_reg  <= '0;
                        ovf_seen_reg <= 1'b0;
                        if (row_cnt_reg == CNT_W'(MAX_ROWS - 1)) begin
                            row_cnt_reg <= '0;
                        end else begin
                            row_cnt_reg <= row_cnt_reg + CNT_W'(1);
                        end
                    end
                    csr_spmv_pkg::CMD_RESTART: begin
                        row_sum_reg  <= '0;
                        ovf_seen_reg <= 1'b0;
                        row_cnt_reg  <= '0;
                    end
                    default: begin
                        row_sum_reg <= row_sum_reg;
                    end
                endcase
            end
        end
        p3_sum_reg   <= row_sum_reg;
        p3_ovf_reg   <= ovf_seen_reg;
        p3_idx_reg   <= idx_wide[ROW_W-1:0];
        p3_bprod_reg <= p2_prod_reg;
    end

    // ------------------------------------------------------------------
    // Stage 4: alpha times the upper and lower halves of the row sum.
    // ------------------------------------------------------------------
    logic              p4_valid_reg;
    logic [HI_W-1:0]   p4_mhi_reg;
    logic [LO_W-1:0]   p4_mlo_reg;
    logic [PROD_W-1:0] p4_bprod_reg;
    logic              p4_ovf_reg;
    logic [ROW_W-1:0]  p4_idx_reg;
    logic [HALF_W:0]   lo_ext;

    assign lo_ext = {1'b0, p3_sum_reg[HALF_W-1:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p4_valid_reg <= 1'b0;
        end else begin
            p4_valid_reg <= p3_valid_reg;
        end
        p4_mhi_reg   <= HI_W'($signed(alpha_reg) * $signed(p3_sum_reg[SUM_W-1:HALF_W]));
        p4_mlo_reg   <= LO_W'($signed(alpha_reg) * $signed(lo_ext));
        p4_bprod_reg <= p3_bprod_reg;
        p4_ovf_reg   <= p3_ovf_reg;
        p4_idx_reg   <= p3_idx_reg;
    end

    // ------------------------------------------------------------------
    // Stage 5: lower part plus beta*prior_y, upper part scaled by 2^8.
    // ------------------------------------------------------------------
    logic               p5_valid_reg;
    logic [PROD_W-1:0]  p5_upper_reg;
    logic [LOWER_W-1:0] p5_lower_reg;
    logic               p5_ovf_reg;
    logic [ROW_W-1:0]   p5_idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p5_valid_reg <= 1'b0;
        end else begin
            p5_valid_reg <= p4_valid_reg;
        end
        p5_upper_reg <= {p4_mhi_reg, 8'h00};
        p5_lower_reg <= LOWER_W'($signed(p4_mlo_reg)) + LOWER_W'($signed(p4_bprod_reg));
        p5_ovf_reg   <= p4_ovf_reg;
        p5_idx_reg   <= p4_idx_reg;
    end

    // ------------------------------------------------------------------
    // Final sum, floor of the lower part, and 32-bit saturation.
    // ------------------------------------------------------------------
    logic [RES_W-1:0]      res_wide;
    logic                  res_hi;
    logic                  res_lo;
    csr_spmv_pkg::result_t res_word;

    assign res_wide = RES_W'($signed(p5_upper_reg))
                    + RES_W'($signed(p5_lower_reg[LOWER_W-1:16]));
    assign res_hi   = ($signed(res_wide) > $signed(RES_W'(32'sh7FFF_FFFF)));
    assign res_lo   = ($signed(res_wide) < $signed({{(RES_W-VAL_W){1'b1}},
                                                    1'b1, {(VAL_W-1){1'b0}}}));

    always_comb begin
        res_word.row_index = p5_idx_reg;
        res_word.saturated = p5_ovf_reg || res_hi || res_lo;
        if (res_hi) begin
            res_word.row_result = {1'b0, {(VAL_W-1){1'b1}}};
        end else if (res_lo) begin
            res_word.row_result = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            res_word.row_result = res_wide[VAL_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Result queue.
    // ------------------------------------------------------------------
    csr_spmv_pkg::result_t q_mem_reg [Q_DEPTH];
    logic [QP_W:0]         q_wr_reg;
    logic [QP_W:0]         q_rd_reg;
    csr_spmv_pkg::result_t q_head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_wr_reg <= '0;
            q_rd_reg <= '0;
        end else begin
            if (p5_valid_reg) begin
                q_wr_reg <= q_wr_reg + (QP_W+1)'(1);
            end
            if (m_accept) begin
                q_rd_reg <= q_rd_reg + (QP_W+1)'(1);
            end
        end
        if (p5_valid_reg) begin
            q_mem_reg[q_wr_reg[QP_W-1:0]] <= res_word;
        end
    end

    assign q_head   = q_mem_reg[q_rd_reg[QP_W-1:0]];
    assign m_tvalid = (q_wr_reg != q_rd_reg);
    assign m_tdata  = {{(csr_spmv_pkg::M_DATA_W-ROW_W-VAL_W){1'b0}},
                       q_head.row_result, q_head.row_index};
    assign m_tuser  = {{(csr_spmv_pkg::M_USER_W-1){1'b0}}, q_head.saturated};

endmodule

`default_nettype wire

// File: test/csr_spmv_row_accumulator_tb.sv
// Self-checking testbench for the CSR sparse matrix-vector row accumulator.
// Drives command words on the input stream, scales over APB and checks each row result
// against a local fixed-point predictor. Depends on csr_spmv_pkg and the top level.
`timescale 1ns / 1ps

module csr_spmv_row_accumulator_tb;

    localparam int COL_W    = csr_spmv_pkg::COL_W;
    localparam int VAL_W    = csr_spmv_pkg::VAL_W;
    localparam int ROW_W    = csr_spmv_pkg::ROW_W;
    localparam int SUM_W    = csr_spmv_pkg::SUM_W;
    localparam int S_DATA_W = csr_spmv_pkg::S_DATA_W;
    localparam int S_USER_W = csr_spmv_pkg::S_USER_W;
    localparam int M_DATA_W = csr_spmv_pkg::M_DATA_W;
    localparam int M_USER_W = csr_spmv_pkg::M_USER_W;
    localparam int APB_AW   = csr_spmv_pkg::APB_AW;
    localparam int APB_DW   = csr_spmv_pkg::APB_DW;

    typedef csr_spmv_pkg::cmd_t    cmd_t;
    typedef csr_spmv_pkg::result_t result_t;

    localparam cmd_t CMD_LOAD_X  = csr_spmv_pkg::CMD_LOAD_X;
    localparam cmd_t CMD_NONZERO = csr_spmv_pkg::CMD_NONZERO;
    localparam cmd_t CMD_END_ROW = csr_spmv_pkg::CMD_END_ROW;
    localparam cmd_t CMD_RESTART = csr_spmv_pkg::CMD_RESTART;

    localparam logic REG_ALPHA = csr_spmv_pkg::REG_ALPHA;
    localparam logic REG_BETA  = csr_spmv_pkg::REG_BETA;

    localparam logic [VAL_W-1:0] ALPHA_RESET = csr_spmv_pkg::ALPHA_RESET;
    localparam logic [VAL_W-1:0] BETA_RESET  = csr_spmv_pkg::BETA_RESET;

    localparam int  X_DEPTH_TB    = 4096;   // matches the block's default store depth
    localparam int  SETTLE_CYCLES = 12;     // row latency plus margin
    localparam int  HOLD_CYCLES   = 300;    // long receiver hold-off
    localparam int  QUIET_LIMIT   = 2000;   // cycles without any transfer
    localparam int  PHASE_WORDS   = 300;

    localparam logic signed [63:0] SUM_HI = (64'sd1 <<< (SUM_W - 1)) - 64'sd1;
    localparam logic signed [63:0] SUM_LO = -(64'sd1 <<< (SUM_W - 1));
    localparam logic signed [81:0] RES_HI = 82'sd2147483647;
    localparam logic signed [81:0] RES_LO = -82'sd2147483648;

    // One input word before packing.
    typedef struct {
        cmd_t             cmd;
        logic [COL_W-1:0] column;
        logic [VAL_W-1:0] x_entry;
        logic [VAL_W-1:0] matrix_entry;
        logic [VAL_W-1:0] prior_y;
    } spmv_word_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // [11:0] column, [43:12] x_entry, [75:44] matrix_entry, [107:76] prior_y
    logic [S_DATA_W-1:0]   s_tdata  = '0;
    // [1:0] command
    logic [S_USER_W-1:0]   s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // [19:0] row_index, [51:20] row_result
    logic [M_DATA_W-1:0]   m_tdata;
    // [0] saturated
    logic [M_USER_W-1:0]   m_tuser;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_AW-1:0]     paddr    = '0;
    logic [APB_DW-1:0]     pwdata   = '0;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    // Predictor state.
    logic [VAL_W-1:0]         x_mem [X_DEPTH_TB];
    bit                       x_loaded [X_DEPTH_TB];
    logic [COL_W-1:0]         loaded_cols [$];
    logic signed [SUM_W-1:0]  row_sum   = '0;
    logic [ROW_W-1:0]         row_count = '0;
    bit                       sum_clamped;
    logic signed [VAL_W-1:0]  alpha_q   = ALPHA_RESET;
    logic signed [VAL_W-1:0]  beta_q    = BETA_RESET;
    result_t                  expected_rows [$];

    int  mismatches     = 0;
    int  hold_left      = 0;
    bit  hold_request   = 1'b0;
    bit  sender_gaps    = 1'b1;
    bit  receiver_gaps  = 1'b1;

    csr_spmv_row_accumulator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #4 aclk = ~aclk;

    // Applies one accepted word to the predictor and queues the row it closes, if any.
    function automatic void advance_spmv(input spmv_word_t w);
        logic signed [63:0] product;
        logic signed [63:0] sum_next;
        logic signed [81:0] scaled;
        logic signed [81:0] shifted;
        result_t            row;
        case (w.cmd)
            CMD_LOAD_X: begin
                x_mem[w.column] = w.x_entry;
                if (!x_loaded[w.column]) begin
                    x_loaded[w.column] = 1'b1;
                    loaded_cols = {loaded_cols, w.column};
                end
            end
            CMD_NONZERO: begin
                // Arithmetic shift floors the full product to Q16.16.
                product  = $signed(w.matrix_entry) * $signed(x_mem[w.column]);
                sum_next = row_sum + (product >>> 16);
                if (sum_next > SUM_HI) begin
                    sum_next    = SUM_HI;
                    sum_clamped = 1'b1;
                end else if (sum_next < SUM_LO) begin
                    sum_next    = SUM_LO;
                    sum_clamped = 1'b1;
                end
                row_sum = sum_next[SUM_W-1:0];
            end
            CMD_RESTART: begin
                row_count   = '0;
                row_sum     = '0;
                sum_clamped = 1'b0;
            end
            default: begin
                // Both products are summed exactly before the single floor shift.
                scaled  = alpha_q * row_sum + beta_q * $signed(w.prior_y);
                shifted = scaled >>> 16;
                row.saturated = sum_clamped;
                if (shifted > RES_HI) begin
                    shifted       = RES_HI;
                    row.saturated = 1'b1;
                end else if (shifted < RES_LO) begin
                    shifted       = RES_LO;
                    row.saturated = 1'b1;
                end
                row.row_result = shifted[VAL_W-1:0];
                row.row_index  = row_count;
                expected_rows  = {expected_rows, row};
                row_count   = row_count + 1'b1;
                row_sum     = '0;
                sum_clamped = 1'b0;
            end
        endcase
    endfunction

    // Q16.16 value: mostly small magnitudes, with the extremes and full-range values mixed in.
    function automatic logic [VAL_W-1:0] rand_q16();
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom();
            default: return $urandom_range(32'h0020_0000) - 32'h0010_0000;
        endcase
    endfunction

    // Offers one word, waits for it to be taken, then updates the predictor.
    task automatic send_word(input spmv_word_t w);
        if (sender_gaps && $urandom_range(99) < 6) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= S_USER_W'(w.cmd);
        s_tdata  <= S_DATA_W'({w.prior_y, w.matrix_entry, w.x_entry, w.column});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        advance_spmv(w);
    endtask

    // Stops sending and lets every outstanding row come out, plus the pipeline depth.
    task automatic wait_until_idle();
        s_tvalid <= 1'b0;
        while (expected_rows.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes both scale registers back to back over APB.
    task automatic write_scales(input logic [VAL_W-1:0] alpha, input logic [VAL_W-1:0] beta);
        for (int i = 0; i < 2; i++) begin
            psel    <= 1'b1;
            pwrite  <= 1'b1;
            penable <= 1'b0;
            paddr   <= {(i == 0) ? REG_ALPHA : REG_BETA, 2'b00};
            pwdata  <= (i == 0) ? alpha : beta;
            @(posedge aclk);
            penable <= 1'b1;
            @(posedge aclk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        alpha_q = alpha;
        beta_q  = beta;
    endtask

    // Rows of random length over loaded columns, with loose loads and restarts in between.
    task automatic run_random_rows(input int n_words);
        spmv_word_t w;
        int         sent;
        int         nnz;
        int         pick;
        sent = 0;
        while (sent < n_words) begin
            w.column       = COL_W'($urandom_range(4095));
            w.x_entry      = rand_q16();
            w.matrix_entry = rand_q16();
            w.prior_y      = rand_q16();
            pick = $urandom_range(99);
            if (pick < 12) begin
                w.cmd = CMD_LOAD_X;
                send_word(w);
                sent++;
            end else if (pick < 15) begin
                w.cmd = CMD_RESTART;
                send_word(w);
                sent++;
            end else begin
                nnz = $urandom_range(0, 6);
                repeat (nnz) begin
                    // A restart now and then breaks a row in the middle.
                    w.cmd = ($urandom_range(49) == 0) ? CMD_RESTART : CMD_NONZERO;
                    w.column       = loaded_cols[$urandom_range(loaded_cols.size() - 1)];
                    w.matrix_entry = rand_q16();
                    w.x_entry      = $urandom();
                    send_word(w);
                end
                w.cmd     = CMD_END_ROW;
                w.column  = COL_W'($urandom());
                w.prior_y = rand_q16();
                send_word(w);
                sent += nnz + 1;
            end
        end
    endtask

    // Field extremes, floor of a negative product, the lower sum limit, restart.
    task automatic test_directed_cases();
        send_word('{CMD_LOAD_X,  12'd0,    32'h7FFF_FFFF, 32'h0,         32'h0});
        send_word('{CMD_LOAD_X,  12'd4095, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
        send_word('{CMD_LOAD_X,  12'd1,    32'h0001_0000, 32'h0,         32'h0});
        send_word('{CMD_LOAD_X,  12'd3,    32'hFFFF_FFFF, 32'h0,         32'h0});
        // Two maximal products bring the row sum close to its upper limit without reaching it.
        send_word('{CMD_NONZERO, 12'd0,    32'h0,         32'h7FFF_FFFF, 32'h0});
        send_word('{CMD_NONZERO, 12'd0,    32'h0,         32'h7FFF_FFFF, 32'h0});
        send_word('{CMD_END_ROW, 12'd0,    32'h0,         32'h0,         32'h7FFF_FFFF});
        // Three large negative products reach the lower limit.
        send_word('{CMD_NONZERO, 12'd4095, 32'h0,         32'h7FFF_FFFF, 32'h0});
        send_word('{CMD_NONZERO, 12'd4095, 32'h0,         32'h7FFF_FFFF, 32'h0});
        send_word('{CMD_NONZERO, 12'd4095, 32'h0,         32'h7FFF_FFFF, 32'h0});
        send_word('{CMD_END_ROW, 12'd4095, 32'h0,         32'h0,         32'h8000_0000});
        // Smallest negative product floors to minus one unit.
        send_word('{CMD_NONZERO, 12'd3,    32'h0,         32'h0000_0001, 32'h0});
        send_word('{CMD_END_ROW, 12'd0,    32'h0,         32'h0,         32'h0});
        send_word('{CMD_NONZERO, 12'd1,    32'h0,         32'h8000_0000, 32'h0});
        send_word('{CMD_END_ROW, 12'd0,    32'h0,         32'h0,         32'h0});
        // A restart drops a partial row and the row count.
        send_word('{CMD_NONZERO, 12'd0,    32'h0,         32'h7FFF_FFFF, 32'h0});
        send_word('{CMD_RESTART, 12'd0,    32'h0,         32'h0,         32'h0});
        send_word('{CMD_END_ROW, 12'd4095, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
        send_word('{CMD_END_ROW, 12'd0,    32'h0,         32'h0,         32'h8000_0000});
        send_word('{CMD_LOAD_X,  12'd4095, 32'h0,         32'h0,         32'h0});
        send_word('{CMD_NONZERO, 12'd4095, 32'h0,         32'h8000_0000, 32'h0});
        send_word('{CMD_END_ROW, 12'd0,    32'h0,         32'h0,         32'h0});
        wait_until_idle();
    endtask

    // Random rows under a series of scale settings, extremes first.
    task automatic test_scale_settings();
        logic [VAL_W-1:0] alpha_set [6];
        logic [VAL_W-1:0] beta_set  [6];
        alpha_set = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, $urandom(), 32'h0000_8000,
                      ALPHA_RESET};
        beta_set  = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, $urandom(), 32'hFFFF_0000,
                      BETA_RESET};
        for (int i = 0; i < 6; i++) begin
            write_scales(alpha_set[i], beta_set[i]);
            // One phase runs both sides flat out.
            sender_gaps   = (i != 2);
            receiver_gaps = (i != 2);
            run_random_rows(PHASE_WORDS);
            wait_until_idle();
        end
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;
    endtask

    // The receiver holds off long enough for the result queue to fill and stall the input.
    task automatic test_backpressure();
        spmv_word_t w;
        hold_request = 1'b1;
        for (int i = 0; i < 40; i++) begin
            w.cmd          = (i % 3 == 0) ? CMD_NONZERO : CMD_END_ROW;
            w.column       = loaded_cols[$urandom_range(loaded_cols.size() - 1)];
            w.x_entry      = $urandom();
            w.matrix_entry = rand_q16();
            w.prior_y      = rand_q16();
            send_word(w);
        end
        wait_until_idle();
    endtask

    // Receiver ready: random short stalls, plus the long hold-off on request.
    always @(posedge aclk) begin
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (receiver_gaps && $urandom_range(99) < 6) begin
            m_tready <= 1'b0;
            hold_left = $urandom_range(0, 2);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Compares each result word with the oldest predicted row.
    always @(posedge aclk) begin : row_check
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_rows.size() == 0) begin
                $display("%0t: unexpected row: index %0d result %h sat %0b", $time,
                         m_tdata[ROW_W-1:0], m_tdata[ROW_W+VAL_W-1:ROW_W], m_tuser[0]);
                mismatches++;
            end else begin
                want = expected_rows.pop_front();
                if (m_tdata[ROW_W-1:0] !== want.row_index ||
                    m_tdata[ROW_W+VAL_W-1:ROW_W] !== want.row_result ||
                    m_tuser[0] !== want.saturated) begin
                    $display({"%0t: row mismatch: expected index %0d result %h sat %0b,",
                              " got index %0d result %h sat %0b"},
                             $time, want.row_index, want.row_result, want.saturated,
                             m_tdata[ROW_W-1:0], m_tdata[ROW_W+VAL_W-1:ROW_W], m_tuser[0]);
                    mismatches++;
                end
            end
        end
    end

    // Ends the run when nothing moves on any port for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
                quiet = 0;
            else
                quiet++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_cases();
        test_scale_settings();
        test_backpressure();
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/csr_spmv_pkg.sv
hw/rtl/csr_spmv_ram.sv
hw/rtl/csr_spmv_row_accumulator.sv
test/csr_spmv_row_accumulator_tb.sv
